### hw/rtl/pwmm_pkg.sv
`default_nettype none
package pwmm_pkg;

  // Field and register widths
  localparam int TIME_WIDTH  = 32;
  localparam int CNT_W       = 32;
  localparam int TICK_US_W   = 16;
  localparam int REPORT_W    = 24;
  localparam int PERIOD_W    = 32;
  localparam int FREQ_W      = 27;
  localparam int DUTY_W      = 10;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // Derived datapath widths
  localparam int PROD_W   = CNT_W + TICK_US_W;
  localparam int SUM_W    = TIME_WIDTH + 1;
  localparam int SCALED_W = TIME_WIDTH + DUTY_W;
  localparam int DIV_N_W  = $clog2(FREQ_W + 1);

  // Constants
  localparam logic [63:0] TIME_MAX64 = (64'd1 << TIME_WIDTH) - 64'd1;
  localparam logic [63:0] CNT_MAX64  = (64'd1 << CNT_W) - 64'd1;
  localparam logic [PROD_W-1:0] PROD_TIME_MAX = PROD_W'(TIME_MAX64);
  localparam logic [SUM_W-1:0] SUM_PERIOD_MAX = SUM_W'(CNT_MAX64);
  localparam logic [FREQ_W-1:0] CENTIHZ_NUM = FREQ_W'(100000000);
  localparam logic [SCALED_W-1:0] DUTY_SCALE = SCALED_W'(1000);
  localparam logic [TICK_US_W-1:0] TICK_US_RESET = TICK_US_W'(1000);
  localparam logic [REPORT_W-1:0] REPORT_TICKS_RESET = REPORT_W'(1000);

  // Quotient bits produced by each divider run
  localparam logic [DIV_N_W-1:0] FREQ_STEPS = DIV_N_W'(FREQ_W);
  localparam logic [DIV_N_W-1:0] DUTY_STEPS = DIV_N_W'(DUTY_W);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_US      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_TICKS = CFG_INDEX_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic count;
    logic mul;
    logic store;
    logic report;
    logic div_start;
    logic div_duty;
    logic freq_load;
    logic out_load;
  } pwmm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic changed;
    logic report_ok;
    logic div_done;
    logic div_busy;
  } pwmm_status_t;

endpackage
`default_nettype wire

### hw/rtl/pwmm_div.sv
`default_nettype none
module pwmm_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [pwmm_pkg::SUM_W-1:0]        num_hi,
  input  wire logic [pwmm_pkg::FREQ_W-1:0]       num_lo,
  input  wire logic [pwmm_pkg::DIV_N_W-1:0]      steps,
  input  wire logic [pwmm_pkg::SUM_W-1:0]        divisor,
  output logic [pwmm_pkg::FREQ_W-1:0]            quotient,
  output logic                                   busy,
  output logic                                   done
);

  logic [pwmm_pkg::SUM_W-1:0]   rem;
  logic [pwmm_pkg::FREQ_W-1:0]  lo;
  logic [pwmm_pkg::DIV_N_W-1:0] cnt;
  logic [pwmm_pkg::SUM_W:0]     trial;
  logic [pwmm_pkg::SUM_W:0]     diff;
  logic                         ge;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem, lo[pwmm_pkg::FREQ_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  // Hold control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == pwmm_pkg::DIV_N_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num_hi;
      lo       <= num_lo;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[pwmm_pkg::SUM_W-1:0] : trial[pwmm_pkg::SUM_W-1:0];
      lo       <= {lo[pwmm_pkg::FREQ_W-2:0], 1'b0};
      quotient <= {quotient[pwmm_pkg::FREQ_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pwmm_dp.sv
`default_nettype none
module pwmm_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pwmm_pkg::pwmm_cmd_t                  cmd,
  output pwmm_pkg::pwmm_status_t                    status,
  input  wire logic                                 cfg_we,
  input  wire logic [pwmm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pwmm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 pin_level,
  output logic [pwmm_pkg::PERIOD_W-1:0]             period_us,
  output logic [pwmm_pkg::FREQ_W-1:0]               frequency_centihz,
  output logic [pwmm_pkg::DUTY_W-1:0]               duty_tenths_percent
);

  logic [pwmm_pkg::TICK_US_W-1:0]  tick_us;
  logic [pwmm_pkg::REPORT_W-1:0]   report_ticks;
  logic                            last_level;
  logic [pwmm_pkg::CNT_W-1:0]      tick_count;
  logic [pwmm_pkg::CNT_W-1:0]      ticks_since_report;
  logic [pwmm_pkg::TIME_WIDTH-1:0] high_time;
  logic [pwmm_pkg::TIME_WIDTH-1:0] low_time;
  logic [pwmm_pkg::PROD_W-1:0]     prod;
  logic [pwmm_pkg::SUM_W-1:0]      sum;
  logic [pwmm_pkg::FREQ_W-1:0]     freq;
  logic [pwmm_pkg::TIME_WIDTH-1:0] time_sat;
  logic [pwmm_pkg::SCALED_W-1:0]   high_scaled;
  logic [pwmm_pkg::SUM_W-1:0]      div_hi;
  logic [pwmm_pkg::FREQ_W-1:0]     div_lo;
  logic [pwmm_pkg::DIV_N_W-1:0]    div_steps;
  logic [pwmm_pkg::FREQ_W-1:0]     div_q;
  logic                            div_busy;
  logic                            div_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us      <= pwmm_pkg::TICK_US_RESET;
      report_ticks <= pwmm_pkg::REPORT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pwmm_pkg::REG_TICK_US:      tick_us      <= cfg_data[pwmm_pkg::TICK_US_W-1:0];
        pwmm_pkg::REG_REPORT_TICKS: report_ticks <= cfg_data[pwmm_pkg::REPORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the product to the time width
  always_comb begin
    time_sat = (prod > pwmm_pkg::PROD_TIME_MAX) ? pwmm_pkg::TIME_WIDTH'(pwmm_pkg::TIME_MAX64)
                                                : pwmm_pkg::TIME_WIDTH'(prod);
  end

  // Counters, level and measured times
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level         <= 1'b0;
      tick_count         <= '0;
      ticks_since_report <= '0;
      high_time          <= '0;
      low_time           <= '0;
    end else begin
      if (cmd.count) begin
        if (tick_count != '1) tick_count <= tick_count + 1'b1;
        if (ticks_since_report != '1) ticks_since_report <= ticks_since_report + 1'b1;
      end
      if (cmd.store) begin
        if (last_level) high_time <= time_sat;
        else            low_time  <= time_sat;
        last_level <= ~last_level;
        tick_count <= '0;
      end
      if (cmd.report) ticks_since_report <= '0;
    end
  end

  // Time product and report sum
  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= pwmm_pkg::PROD_W'(tick_count) * pwmm_pkg::PROD_W'(tick_us);
    if (cmd.report) sum <= pwmm_pkg::SUM_W'(high_time) + pwmm_pkg::SUM_W'(low_time);
  end

  // Select the numerator for the shared divider
  always_comb begin
    high_scaled = pwmm_pkg::SCALED_W'(high_time) * pwmm_pkg::DUTY_SCALE;
    if (cmd.div_duty) begin
      div_hi    = pwmm_pkg::SUM_W'(high_scaled[pwmm_pkg::SCALED_W-1:pwmm_pkg::DUTY_W]);
      div_lo    = {high_scaled[pwmm_pkg::DUTY_W-1:0],
                   (pwmm_pkg::FREQ_W - pwmm_pkg::DUTY_W)'(0)};
      div_steps = pwmm_pkg::DUTY_STEPS;
    end else begin
      div_hi    = '0;
      div_lo    = pwmm_pkg::CENTIHZ_NUM;
      div_steps = pwmm_pkg::FREQ_STEPS;
    end
  end

  pwmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num_hi   (div_hi),
    .num_lo   (div_lo),
    .steps    (div_steps),
    .divisor  (sum),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.freq_load) freq <= div_q;
    if (cmd.out_load) begin
      period_us           <= (sum > pwmm_pkg::SUM_PERIOD_MAX) ? '1 : pwmm_pkg::PERIOD_W'(sum);
      frequency_centihz   <= freq;
      duty_tenths_percent <= div_q[pwmm_pkg::DUTY_W-1:0];
    end
  end

  // Status back to the controller
  always_comb begin
    status.changed   = pin_level != last_level;
    status.report_ok = (high_time != '0) && (low_time != '0) &&
                       (ticks_since_report >= pwmm_pkg::CNT_W'(report_ticks));
    status.div_done  = div_done;
    status.div_busy  = div_busy;
  end

endmodule
`default_nettype wire

### hw/rtl/pwmm_ctrl.sv
`default_nettype none
module pwmm_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire pwmm_pkg::pwmm_status_t status,
  output pwmm_pkg::pwmm_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_STORE  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_FSTART = 4'd4;
  localparam logic [3:0] S_FREQ   = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DUTY   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;
  logic       slot_free;

  assign in_ready  = state == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.count = accept;
        if (accept && status.changed) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.report_ok) begin
          cmd.report = 1'b1;
          state_next = S_FSTART;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_FREQ;
      end
      S_FREQ: begin
        if (status.div_done) begin
          cmd.freq_load = 1'b1;
          state_next    = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_duty  = 1'b1;
        state_next    = S_DUTY;
      end
      S_DUTY: begin
        if (status.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pwm_period_duty_meter_unit.sv
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    pin_level
// out      source     out_valid / out_ready  period_us, frequency_centihz, duty_tenths_percent
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick without a level change is taken in IDLE; a change also passes MUL, STORE and CHECK.
// A change that reports then runs the one-bit-per-cycle divider in FREQ and DUTY,
// for 27 frequency bits and then 10 duty bits, plus any wait in OUT for the output slot.
// Synchronous active-high reset clears counters, times and control; registers
// return to 1000. A waiting result does not block ticks until the next report.
module pwm_period_duty_meter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              pin_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [pwmm_pkg::PERIOD_W-1:0]          period_us,
  output logic [pwmm_pkg::FREQ_W-1:0]            frequency_centihz,
  output logic [pwmm_pkg::DUTY_W-1:0]            duty_tenths_percent,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pwmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pwmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pwmm_pkg::pwmm_cmd_t    cmd;
  pwmm_pkg::pwmm_status_t status;

  assign cfg_ready = 1'b1;

  pwmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pwmm_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .pin_level           (pin_level),
    .period_us           (period_us),
    .frequency_centihz   (frequency_centihz),
    .duty_tenths_percent (duty_tenths_percent)
  );

  // Never overwrite a result that is still waiting
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting item");

  // Divider is never restarted mid-run
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // No tick is taken while a division runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> !in_ready)
    else $error("input ready during division");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import pwmm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_TICKS = 900;
  localparam int RANDOM_PHASES = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;
  localparam logic [63:0] CENTIHZ_SCALE = 64'd100_000_000;
  localparam logic [63:0] DUTY_FULL = 64'd1000;
  localparam logic [63:0] TIME_CEIL = (64'd1 << TIME_WIDTH) - 64'd1;
  localparam logic [CNT_W-1:0] CNT_CEIL = '1;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
    logic [DUTY_W-1:0]   duty;
  } meter_report_t;

  // Tracks the meter's state per accepted tick and holds the reports still owed
  class pwm_meter_scoreboard;
    logic [TICK_US_W-1:0] tick_us;
    logic [REPORT_W-1:0]  report_ticks;
    logic                 last_level;
    logic [CNT_W-1:0]     run_ticks;
    logic [CNT_W-1:0]     ticks_since_report;
    logic [63:0]          high_us;
    logic [63:0]          low_us;
    meter_report_t        reports_due[$];
    int                   mismatches;

    function new();
      tick_us = TICK_US_RESET;
      report_ticks = REPORT_TICKS_RESET;
      last_level = 1'b0;
      run_ticks = '0;
      ticks_since_report = '0;
      high_us = '0;
      low_us = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TICK_US) begin
        tick_us = data[TICK_US_W-1:0];
      end else if (idx == REG_REPORT_TICKS) begin
        report_ticks = data[REPORT_W-1:0];
      end
    endfunction

    function void note_tick(logic level);
      logic [63:0]   span_us;
      logic [63:0]   sum_us;
      meter_report_t rep;
      // Count the current tick before looking for an edge
      if (run_ticks != CNT_CEIL) run_ticks++;
      if (ticks_since_report != CNT_CEIL) ticks_since_report++;
      if (level != last_level) begin
        span_us = 64'(run_ticks) * 64'(tick_us);
        if (span_us > TIME_CEIL) span_us = TIME_CEIL;
        if (last_level) begin
          high_us = span_us;
        end else begin
          low_us = span_us;
        end
        if (high_us != 0 && low_us != 0 && ticks_since_report >= CNT_W'(report_ticks)) begin
          sum_us = high_us + low_us;
          rep.period = (sum_us > 64'(CNT_CEIL)) ? {PERIOD_W{1'b1}} : sum_us[PERIOD_W-1:0];
          rep.freq = FREQ_W'(CENTIHZ_SCALE / sum_us);
          rep.duty = DUTY_W'((high_us * DUTY_FULL) / sum_us);
          reports_due.push_back(rep);
          ticks_since_report = '0;
        end
        last_level = level;
        run_ticks = '0;
      end
    endfunction

    function void check_result(logic [PERIOD_W-1:0] period, logic [FREQ_W-1:0] freq,
                               logic [DUTY_W-1:0] duty);
      meter_report_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: report with none owed: period %0d freq %0d duty %0d",
                 $time, period, freq, duty);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      if (period !== want.period) begin
        $display("%0t: period_us expected %0d actual %0d", $time, want.period, period);
        mismatches++;
      end
      if (freq !== want.freq) begin
        $display("%0t: frequency_centihz expected %0d actual %0d", $time, want.freq, freq);
        mismatches++;
      end
      if (duty !== want.duty) begin
        $display("%0t: duty_tenths_percent expected %0d actual %0d", $time, want.duty, duty);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   pin_level;
  logic                   out_valid;
  logic                   out_ready;
  logic [PERIOD_W-1:0]    period_us;
  logic [FREQ_W-1:0]      frequency_centihz;
  logic [DUTY_W-1:0]      duty_tenths_percent;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pwm_meter_scoreboard sb = new();
  bit                  tx_gaps;
  bit                  rx_stalls;
  int unsigned         cycles;

  pwm_period_duty_meter_unit i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .pin_level           (pin_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .period_us           (period_us),
    .frequency_centihz   (frequency_centihz),
    .duty_tenths_percent (duty_tenths_percent),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL pwm_period_duty_meter_unit");
      $finish;
    end
  end

  // Observe every handshake; results first, as they belong to older ticks
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(period_us, frequency_centihz,
                                                  duty_tenths_percent);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_tick(pin_level);
    end
  end

  // Result side: stall in random bursts while enabled
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic pause_sender(input int n_cycles);
    in_valid <= 1'b0;
    repeat (n_cycles) @(posedge clk);
  endtask

  // Offer one tick and hold it until taken; valid stays high for the next item
  task automatic send_tick(input logic level);
    in_valid <= 1'b1;
    pin_level <= level;
    do @(posedge clk); while (!in_ready);
    if (tx_gaps && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 13));
  endtask

  task automatic hold_level(input logic level, input int n_ticks);
    repeat (n_ticks) send_tick(level);
  endtask

  // Stop ticks, wait for every owed report, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram both registers once idle; junk above each field must be dropped
  task automatic configure(input logic [TICK_US_W-1:0] us,
                           input logic [REPORT_W-1:0] gate_ticks);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    junk = $urandom;
    cfg_write(REG_TICK_US, {junk[CFG_DATA_W-1:TICK_US_W], us});
    junk = $urandom;
    cfg_write(REG_REPORT_TICKS, {junk[CFG_DATA_W-1:REPORT_W], gate_ticks});
    cfg_write(CFG_INDEX_W'($urandom_range(REG_REPORT_TICKS + 1, REG_UNMAPPED)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Square-ish wave with random run lengths, now and then a long run
  task automatic random_wave(input int n_ticks);
    int   sent;
    int   run;
    logic level;
    sent = 0;
    level = 1'($urandom_range(0, 1));
    while (sent < n_ticks) begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
      hold_level(level, run);
      sent += run;
      level = ~level;
    end
  endtask

  initial begin
    logic [TICK_US_W-1:0] us;
    logic [REPORT_W-1:0]  gate_ticks;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pin_level <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Unmapped register write must change nothing
    cfg_write(REG_UNMAPPED, '1);
    cfg_valid <= 1'b0;

    // Reset settings: edges and a steady level, report gate not yet reached
    hold_level(1'b0, 2);
    send_tick(1'b1);
    send_tick(1'b0);

    // Shortest tick, report on every edge once both times are known
    configure(16'd1, 24'd0);
    hold_level(1'b1, 2);
    send_tick(1'b0);
    send_tick(1'b1);
    hold_level(1'b0, 3);
    send_tick(1'b1);

    // Zero tick length stores zero times, so nothing reports
    configure(16'd0, 24'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Longest tick: long runs give periods of tens of seconds
    configure('1, 24'd1);
    send_tick(1'b0);
    send_tick(1'b1);
    hold_level(1'b1, 300);
    send_tick(1'b0);
    hold_level(1'b0, 300);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Widest report gate blocks every report
    configure(16'd1, '1);
    repeat (10) begin
      send_tick(1'b1);
      send_tick(1'b0);
    end

    // Two-microsecond period gives the top frequency
    configure(16'd1, 24'd1);
    repeat (3) begin
      send_tick(1'b1);
      send_tick(1'b0);
    end

    // Random phases; the last runs with no idling on either side
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_gaps = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_stalls = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: us = 16'd1;
        1: us = '1;
        2: us = TICK_US_W'($urandom_range(1, 40));
        default: us = TICK_US_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: gate_ticks = 24'd1;
        1: gate_ticks = REPORT_W'($urandom_range(1, 12));
        2: gate_ticks = REPORT_W'($urandom_range(13, 200));
        default: gate_ticks = 24'd0;
      endcase
      configure(us, gate_ticks);
      random_wave(RANDOM_TICKS / RANDOM_PHASES);
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("PASS pwm_period_duty_meter_unit");
    end else begin
      $display("FAIL pwm_period_duty_meter_unit");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pwmm_pkg.sv
hw/rtl/pwmm_div.sv
hw/rtl/pwmm_dp.sv
hw/rtl/pwmm_ctrl.sv
hw/rtl/pwm_period_duty_meter_unit.sv
verif/tb_top.sv
